@@ sv/tdlc_pkg.sv @@
// shared types, byte codes and character class helpers for the display length counter
package tdlc_pkg;

  typedef enum logic [2:0] {
    PS_NORMAL      = 3'd0,
    PS_AFTER_ESC   = 3'd1,
    PS_SEEK_LETTER = 3'd2,
    PS_SEEK_EQUALS = 3'd3,
    PS_DIGITS      = 3'd4
  } parse_state_t;

  localparam logic [7:0] BYTE_NUL    = 8'h00;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_GT     = 8'h3E;
  localparam logic [7:0] BYTE_BTICK  = 8'h60;
  localparam logic [7:0] BYTE_AT     = 8'h40;
  localparam logic [7:0] BYTE_EQ     = 8'h3D;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;

  localparam int unsigned LEN_WIDTH = 16;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_control(input logic [7:0] c);
    return (c < BYTE_SPACE) || (c == BYTE_DEL);
  endfunction

endpackage

@@ sv/terminal_display_length_counter_core.sv @@
// display length counter: escape sequence parser, saturating count and result register
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_stall  | char_byte
//   out     | output    | out_valid / out_stall| visible, length_so_far, done_res
//
// one byte per cycle while in_stall is low; each byte's result shows in the cycle after acceptance.
// the parse state and count update in the cycle the byte is accepted, so the next byte
// follows straight away; only the result register lies between a byte and its result.
// synchronous reset clears the parser to normal, the count to zero and the result valid.
// in_stall rises only while a result is held and out_stall is high.
module terminal_display_length_counter_core
  import tdlc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 visible,
  output logic [LEN_WIDTH-1:0] length_so_far,
  output logic                 done_res
);

  parse_state_t           state, state_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic                   shown;
  logic                   in_take;
  logic                   is_term;
  logic [LEN_WIDTH-1:0]   len_view;

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign is_term  = (char_byte == BYTE_NUL);

  // next parse state
  always_comb begin
    state_next = state;
    if (is_term) begin
      state_next = PS_NORMAL;
    end else begin
      unique case (state)
        PS_AFTER_ESC: begin
          if (char_byte == BYTE_ESC) state_next = PS_NORMAL;
          else if (char_byte == BYTE_LBRACK) state_next = PS_SEEK_LETTER;
          else if (char_byte == BYTE_GT) state_next = PS_SEEK_EQUALS;
          else if ((char_byte == BYTE_BTICK) || is_letter(char_byte)) state_next = PS_NORMAL;
          else if (is_digit(char_byte)) state_next = PS_DIGITS;
          else state_next = PS_SEEK_LETTER;
        end
        PS_SEEK_LETTER: begin
          if (is_letter(char_byte) || (char_byte == BYTE_BTICK) || (char_byte == BYTE_AT))
            state_next = PS_NORMAL;
        end
        PS_SEEK_EQUALS: state_next = PS_NORMAL;
        PS_DIGITS: begin
          if (is_letter(char_byte)) state_next = PS_NORMAL;
        end
        default: begin
          state_next = (char_byte == BYTE_ESC) ? PS_AFTER_ESC : PS_NORMAL;
        end
      endcase
    end
  end

  // whether this byte is displayed
  always_comb begin
    shown = 1'b0;
    if (!is_term) begin
      unique case (state)
        PS_AFTER_ESC:   shown = (char_byte == BYTE_ESC);
        PS_SEEK_LETTER: shown = 1'b0;
        PS_SEEK_EQUALS: shown = (char_byte != BYTE_EQ);
        PS_DIGITS:      shown = is_letter(char_byte);
        default:        shown = (char_byte != BYTE_ESC) && !is_control(char_byte);
      endcase
    end
  end

  // saturating count
  always_comb begin
    count_next = count;
    if (is_term) count_next = '0;
    else if (shown && (count != {COUNT_WIDTH{1'b1}})) count_next = count + 1'b1;
  end

  // the reported length is the post-update count, or the count before clearing on a terminator
  generate
    if (COUNT_WIDTH >= LEN_WIDTH) begin : g_len_trunc
      assign len_view = is_term ? count[LEN_WIDTH-1:0] : count_next[LEN_WIDTH-1:0];
    end else begin : g_len_ext
      assign len_view = is_term ? LEN_WIDTH'(count) : LEN_WIDTH'(count_next);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PS_NORMAL;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        state <= state_next;
        count <= count_next;
      end
      if (in_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      visible       <= shown;
      length_so_far <= len_view;
      done_res      <= is_term;
    end
  end

`ifndef NO_ASSERTIONS
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (in_take && is_term) |=> (count == '0) && (state == PS_NORMAL))
    else $error("terminator did not clear parser");

  a_done_not_visible: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !visible)
    else $error("terminator result marked visible");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_take && shown && (count != {COUNT_WIDTH{1'b1}}))
      |=> (count == COUNT_WIDTH'($past(count) + 1'b1)))
    else $error("displayed byte did not advance count");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!in_take) |=> $stable(count) && $stable(state))
    else $error("parser state moved without a transaction");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");
`endif

endmodule

@@ bench/terminal_display_length_counter_core_test.sv @@
// self-checking testbench for the terminal display length counter core
`timescale 1ns / 100ps

module terminal_display_length_counter_core_test;
  import tdlc_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic                 vis;
    logic [LEN_WIDTH-1:0] count_val;
    logic                 fin;
  } length_result_t;

  class display_length_checker;
    parse_state_t         state;
    logic [LEN_WIDTH-1:0] shown_count;
    length_result_t       pending_results[$];
    int                   mismatches;

    function new();
      state       = PS_NORMAL;
      shown_count = '0;
      mismatches  = 0;
    endfunction

    static function logic alpha(logic [7:0] c);
      return (c | 8'h20) inside {[8'h61:8'h7A]};
    endfunction

    static function logic digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
    endfunction

    // works out the result of one accepted byte and queues it
    function void note_byte(logic [7:0] c);
      logic shown;
      shown = 1'b0;
      if (c == BYTE_NUL) begin
        pending_results.push_back('{1'b0, shown_count, 1'b1});
        state       = PS_NORMAL;
        shown_count = '0;
      end else begin
        case (state)
          PS_AFTER_ESC: begin
            if (c == BYTE_ESC) begin
              state = PS_NORMAL;
              shown = 1'b1;
            end else if (c == BYTE_LBRACK) begin
              state = PS_SEEK_LETTER;
            end else if (c == BYTE_GT) begin
              state = PS_SEEK_EQUALS;
            end else if (c == BYTE_BTICK || alpha(c)) begin
              state = PS_NORMAL;
            end else if (digit(c)) begin
              state = PS_DIGITS;
            end else begin
              state = PS_SEEK_LETTER;
            end
          end
          PS_SEEK_LETTER: begin
            if (alpha(c) || c == BYTE_BTICK || c == BYTE_AT) state = PS_NORMAL;
          end
          PS_SEEK_EQUALS: begin
            state = PS_NORMAL;
            shown = (c != BYTE_EQ);
          end
          PS_DIGITS: begin
            if (alpha(c)) begin
              state = PS_NORMAL;
              shown = 1'b1;
            end
          end
          default: begin
            if (c == BYTE_ESC) begin
              state = PS_AFTER_ESC;
            end else begin
              state = PS_NORMAL;
              shown = !(c < BYTE_SPACE || c == BYTE_DEL);
            end
          end
        endcase
        // count holds at all ones
        if (shown && shown_count != '1) shown_count = shown_count + 1'b1;
        pending_results.push_back('{shown, shown_count, 1'b0});
      end
    endfunction

    function void check_result(logic vis, logic [LEN_WIDTH-1:0] len, logic fin);
      length_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: visible %0b length_so_far %0d done_res %0b",
               vis, len, fin);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (vis !== want.vis) begin
          $error("visible: expected %0b, got %0b", want.vis, vis);
          mismatches++;
        end
        if (len !== want.count_val) begin
          $error("length_so_far: expected %0d, got %0d", want.count_val, len);
          mismatches++;
        end
        if (fin !== want.fin) begin
          $error("done_res: expected %0b, got %0b", want.fin, fin);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           char_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 visible;
  logic [LEN_WIDTH-1:0] length_so_far;
  logic                 done_res;

  display_length_checker board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int idle_cycles   = 0;

  terminal_display_length_counter_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_byte     (char_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .visible       (visible),
    .length_so_far (length_so_far),
    .done_res      (done_res)
  );

  always #4 clk = ~clk;

  // result side: checks each transaction, then picks next cycle's stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(visible, length_so_far, done_res);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("terminal_display_length_counter_core verification failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_byte(b);
    bytes_sent++;
  endtask

  // sender stops offering until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(8'h41, 8'h5A));
    if ($urandom_range(1)) c = c | 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_non_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (display_length_checker::alpha(c));
    return c;
  endfunction

  // one string of random tokens: plain bytes, escape sequences, maybe one cut short
  task automatic send_random_string();
    int         tokens;
    int         kind;
    logic       cut;
    logic [7:0] b;
    tokens = $urandom_range(1, 10);
    cut    = 1'b0;
    for (int i = 0; i < tokens && !cut; i++) begin
      kind = $urandom_range(0, 13);
      case (kind)
        0, 1, 2, 3: send_byte(8'($urandom_range(8'h20, 8'h7E)));
        4: send_byte(8'($urandom_range(8'h80, 8'hFF)));
        5: send_byte(($urandom_range(3) == 0) ? BYTE_DEL : 8'($urandom_range(1, 31)));
        6: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_LBRACK);
          repeat ($urandom_range(0, 4))
            send_byte($urandom_range(4) == 0 ? 8'h3B : 8'($urandom_range(8'h30, 8'h39)));
          case ($urandom_range(0, 3))
            0: send_byte(BYTE_BTICK);
            1: send_byte(BYTE_AT);
            default: send_byte(rand_letter());
          endcase
        end
        7: begin
          send_byte(BYTE_ESC);
          send_byte($urandom_range(3) == 0 ? BYTE_BTICK : rand_letter());
        end
        8: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_ESC);
        end
        9: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_GT);
          send_byte($urandom_range(1) ? BYTE_EQ : 8'($urandom_range(1, 255)));
        end
        10: begin
          send_byte(BYTE_ESC);
          send_byte(8'($urandom_range(8'h30, 8'h39)));
          repeat ($urandom_range(0, 3)) send_byte(rand_non_letter());
          send_byte(rand_letter());
        end
        11: begin
          send_byte(BYTE_ESC);
          b = rand_non_letter();
          send_byte(b);
          repeat ($urandom_range(0, 2)) send_byte(rand_non_letter());
          send_byte($urandom_range(2) == 0 ? BYTE_AT : rand_letter());
        end
        12: send_byte(8'($urandom_range(1, 255)));
        default: begin
          // string broken off inside an escape sequence
          send_byte(BYTE_ESC);
          case ($urandom_range(0, 3))
            0: send_byte(BYTE_LBRACK);
            1: send_byte(BYTE_GT);
            2: send_byte(8'($urandom_range(8'h30, 8'h39)));
            default: ;
          endcase
          cut = 1'b1;
        end
      endcase
    end
    send_byte(BYTE_NUL);
  endtask

  initial begin
    logic [7:0] directed[$];
    int         target;
    directed = '{BYTE_NUL, 8'h41, 8'h80, 8'hFF, BYTE_DEL, 8'h01, 8'h1F,
                 BYTE_ESC, BYTE_ESC, BYTE_ESC, BYTE_LBRACK, 8'h31, 8'h6D,
                 BYTE_ESC, BYTE_GT, BYTE_EQ, BYTE_ESC, BYTE_GT, BYTE_ESC,
                 BYTE_ESC, 8'h35, 8'h7A, BYTE_ESC, BYTE_BTICK, BYTE_ESC, BYTE_AT,
                 BYTE_AT, BYTE_NUL, BYTE_ESC, BYTE_LBRACK, BYTE_NUL};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 78;
    foreach (directed[i]) send_byte(directed[i]);
    target = bytes_sent + 530;
    while (bytes_sent < target) send_random_string();
    drain();

    send_idle_pct = 78;
    recv_idle_pct = 9;
    target = bytes_sent + 530;
    while (bytes_sent < target) send_random_string();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver holds off while bytes keep coming, so the input backs up
    hold_left = 300;
    target = bytes_sent + 530;
    while (bytes_sent < target) send_random_string();
    drain();

    send_byte(BYTE_NUL);
    send_byte(8'h41);
    send_byte(BYTE_NUL);

    drain();
    repeat (16) @(posedge clk);
    if (board.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", board.pending_results.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("terminal_display_length_counter_core verification clean");
    end else begin
      $display("terminal_display_length_counter_core verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tdlc_pkg.sv
sv/terminal_display_length_counter_core.sv
bench/terminal_display_length_counter_core_test.sv
